// ===== src/ebt_pkg.sv =====
// Shared types and constants for the event blob tracker.
package ebt_pkg;

    localparam int W_BITS     = 16;
    localparam int DIST_W     = 28;
    localparam int CNT_W      = 8;
    localparam int DIV_D_W    = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int ROUND_HALF = 32768;
    localparam int RAD_SCALE  = 10;
    localparam int RAD_GAIN   = 23;

    localparam logic [W_BITS:0] W_ONE = {1'b1, {W_BITS{1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam int CENTER_WEIGHT_RST = 6554;
    localparam int RADIUS_WEIGHT_RST = 6554;
    localparam int RADIUS_LIMIT_RST  = 12800;
    localparam int START_X_RST       = 0;
    localparam int START_Y_RST       = 0;
    localparam int START_RADIUS_RST  = 2560;

    typedef logic [ADDR_W-3:0] reg_idx_t;

    localparam reg_idx_t REG_CENTER_WEIGHT = 3'd0;
    localparam reg_idx_t REG_RADIUS_WEIGHT = 3'd1;
    localparam reg_idx_t REG_RADIUS_LIMIT  = 3'd2;
    localparam reg_idx_t REG_START_X       = 3'd3;
    localparam reg_idx_t REG_START_Y       = 3'd4;
    localparam reg_idx_t REG_START_RADIUS  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT,
        ST_GATE,
        ST_AVG_GO,
        ST_AVG,
        ST_RMUL,
        ST_RSUM,
        ST_RDIV_GO,
        ST_RDIV,
        ST_BLEND,
        ST_COMMIT,
        ST_OUT
    } ebt_state_t;

    typedef struct packed {
        logic load_event;
        logic load_diff;
        logic load_square;
        logic sqrt_start;
        logic load_gate;
        logic div_start;
        logic div_radius;
        logic load_avg;
        logic load_rmul;
        logic load_rsum;
        logic load_radius;
        logic load_blend;
        logic commit;
        logic load_result;
    } ebt_ctrl_t;

endpackage

// ===== src/event_blob_tracker.sv =====
// Event blob tracker top level: gating, center blending and window radius adaptation.
//
//   channel  | handshake                 | word
//   event    | event_valid / event_stall | event_x, event_y
//   result   | result_valid/result_stall | accepted, center_x, center_y, radius_now,
//            |                           | box_width, box_height
//   config   | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// One event at a time. Every event goes through a bit-serial square root; a window-closing event
// also goes through two bit-serial divisions of Q bits (34 at defaults).
// Reset loads the center and radius from the register reset values and clears the window.
// A stalled result word holds in its output register while the next event is processed.
module event_blob_tracker import ebt_pkg::*; #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 8,
    parameter int WINDOW_LEN = 200
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            event_valid,
    output logic                            event_stall,
    input  logic [COORD_BITS-1:0]           event_x,
    input  logic [COORD_BITS-1:0]           event_y,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            accepted,
    output logic [COORD_BITS+FRAC_BITS-1:0] center_x,
    output logic [COORD_BITS+FRAC_BITS-1:0] center_y,
    output logic [COORD_BITS+FRAC_BITS-1:0] radius_now,
    output logic [COORD_BITS-1:0]           box_width,
    output logic [COORD_BITS-1:0]           box_height,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_W-1:0]               paddr,
    input  logic [DATA_W-1:0]               pwdata,
    output logic [DATA_W-1:0]               prdata,
    output logic                            pready
);

    localparam int POS_W   = COORD_BITS + FRAC_BITS;
    localparam int RAD_W   = 2 * POS_W + 2;
    localparam int ROOT_W  = POS_W + 1;
    localparam int SQ_W    = 2 * POS_W;
    localparam int DIFF_W  = POS_W + 1;
    localparam int BL_W    = POS_W + W_BITS + 2;
    localparam int RA_W    = POS_W + W_BITS + 1;
    localparam int RB_W    = DIST_W + W_BITS;
    localparam int NUM_W   = ((RA_W + 4 > RB_W + 5) ? RA_W + 4 : RB_W + 5) + 1;
    localparam int Q_W     = NUM_W - W_BITS;
    localparam int DIV_N_W = (Q_W > DIST_W) ? Q_W : DIST_W;
    localparam int SUM_W   = ((DIST_W > ROOT_W) ? DIST_W : ROOT_W) + 1;

    ebt_state_t state_reg;
    ebt_state_t state_next;
    ebt_ctrl_t  ctrl;

    logic [W_BITS-1:0] center_weight;
    logic [W_BITS-1:0] radius_weight;
    logic [POS_W-1:0]  radius_limit;

    // per-event working registers
    logic [COORD_BITS-1:0]    ex_reg;
    logic [COORD_BITS-1:0]    ey_reg;
    logic [POS_W-1:0]         dx_reg;
    logic [POS_W-1:0]         dy_reg;
    logic signed [DIFF_W-1:0] difx_reg;
    logic signed [DIFF_W-1:0] dify_reg;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic                     hit_reg;
    logic                     close_reg;
    logic [DIST_W-1:0]        avg_reg;
    logic [RA_W-1:0]          ra_reg;
    logic [RB_W-1:0]          rb_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [POS_W-1:0]         rnew_reg;
    logic signed [BL_W-1:0]   blx_reg;
    logic signed [BL_W-1:0]   bly_reg;

    // tracker state
    logic [POS_W-1:0]      pos_x_reg;
    logic [POS_W-1:0]      pos_y_reg;
    logic [POS_W-1:0]      radius_reg;
    logic [DIST_W-1:0]     dist_total_reg;
    logic [CNT_W-1:0]      window_count_reg;
    logic [COORD_BITS-1:0] min_x_reg;
    logic [COORD_BITS-1:0] max_x_reg;
    logic [COORD_BITS-1:0] min_y_reg;
    logic [COORD_BITS-1:0] max_y_reg;
    logic [COORD_BITS-1:0] width_held_reg;
    logic [COORD_BITS-1:0] height_held_reg;

    // result register
    logic                  result_valid_reg;
    logic                  accepted_reg;
    logic [POS_W-1:0]      center_x_reg;
    logic [POS_W-1:0]      center_y_reg;
    logic [POS_W-1:0]      radius_now_reg;
    logic [COORD_BITS-1:0] box_width_reg;
    logic [COORD_BITS-1:0] box_height_reg;

    logic [POS_W-1:0]         qx;
    logic [POS_W-1:0]         qy;
    logic signed [DIFF_W-1:0] difx;
    logic signed [DIFF_W-1:0] dify;
    logic [SQ_W-1:0]          sqx;
    logic [SQ_W-1:0]          sqy;
    logic [RAD_W-1:0]         radicand;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        dist_root;
    logic                     hit_now;
    logic                     close_now;
    logic [DIV_N_W-1:0]       div_dividend;
    logic [DIV_D_W-1:0]       div_divisor;
    logic                     div_done;
    logic [DIV_N_W-1:0]       div_q;
    logic [W_BITS:0]          weight_inv;
    logic [RA_W-1:0]          ra_prod;
    logic [RB_W-1:0]          rb_prod;
    logic [NUM_W-1:0]         num_sum;
    logic signed [BL_W-1:0]   blx_prod;
    logic signed [BL_W-1:0]   bly_prod;
    logic signed [BL_W-1:0]   blx_shift;
    logic signed [BL_W-1:0]   bly_shift;
    logic [POS_W-1:0]         pos_x_next;
    logic [POS_W-1:0]         pos_y_next;
    logic [DIST_W-1:0]        dist_base;
    logic [SUM_W-1:0]         dist_sum;
    logic [DIST_W-1:0]        dist_total_next;
    logic                     out_free;

    ebt_regs #(
        .POS_W (POS_W)
    ) u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .center_weight (center_weight),
        .radius_weight (radius_weight),
        .radius_limit  (radius_limit)
    );

    assign pready = 1'b1;

    ebt_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (dist_root)
    );

    ebt_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // datapath
    assign qx   = {ex_reg, {FRAC_BITS{1'b0}}};
    assign qy   = {ey_reg, {FRAC_BITS{1'b0}}};
    assign difx = $signed({1'b0, qx}) - $signed({1'b0, pos_x_reg});
    assign dify = $signed({1'b0, qy}) - $signed({1'b0, pos_y_reg});
    assign sqx  = dx_reg * dx_reg;
    assign sqy  = dy_reg * dy_reg;
    assign radicand = RAD_W'(sqx_reg) + RAD_W'(sqy_reg);

    assign hit_now   = dist_root < {1'b0, radius_reg};
    assign close_now = hit_now && (window_count_reg == CNT_W'(WINDOW_LEN));

    assign div_dividend = ctrl.div_radius ? DIV_N_W'(num_reg[NUM_W-1:W_BITS])
                                          : DIV_N_W'(dist_total_reg);
    assign div_divisor  = ctrl.div_radius ? DIV_D_W'(RAD_SCALE) : DIV_D_W'(WINDOW_LEN);

    assign weight_inv = W_ONE - {1'b0, radius_weight};
    assign ra_prod    = weight_inv * radius_reg;
    assign rb_prod    = radius_weight * avg_reg;
    assign num_sum    = NUM_W'(ra_reg) * NUM_W'(RAD_SCALE) + NUM_W'(rb_reg) * NUM_W'(RAD_GAIN);

    assign blx_prod  = $signed({1'b0, center_weight}) * difx_reg;
    assign bly_prod  = $signed({1'b0, center_weight}) * dify_reg;
    assign blx_shift = (blx_reg + BL_W'(ROUND_HALF)) >>> W_BITS;
    assign bly_shift = (bly_reg + BL_W'(ROUND_HALF)) >>> W_BITS;
    assign pos_x_next = POS_W'(blx_shift + $signed({{(BL_W-POS_W){1'b0}}, pos_x_reg}));
    assign pos_y_next = POS_W'(bly_shift + $signed({{(BL_W-POS_W){1'b0}}, pos_y_reg}));

    assign dist_base       = close_reg ? '0 : dist_total_reg;
    assign dist_sum        = SUM_W'(dist_base) + SUM_W'(dist_root);
    assign dist_total_next = (dist_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(dist_sum);

    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_event)
        begin
            ex_reg <= event_x;
            ey_reg <= event_y;
        end
        if (ctrl.load_diff)
        begin
            difx_reg <= difx;
            dify_reg <= dify;
            dx_reg   <= difx[DIFF_W-1] ? POS_W'(-difx) : POS_W'(difx);
            dy_reg   <= dify[DIFF_W-1] ? POS_W'(-dify) : POS_W'(dify);
        end
        if (ctrl.load_square)
        begin
            sqx_reg <= sqx;
            sqy_reg <= sqy;
        end
        if (ctrl.load_gate)
        begin
            hit_reg   <= hit_now;
            close_reg <= close_now;
        end
        if (ctrl.load_avg)
        begin
            avg_reg <= DIST_W'(div_q);
        end
        if (ctrl.load_rmul)
        begin
            ra_reg <= ra_prod;
            rb_reg <= rb_prod;
        end
        if (ctrl.load_rsum)
        begin
            num_reg <= num_sum;
        end
        if (ctrl.load_radius)
        begin
            rnew_reg <= (div_q > DIV_N_W'(radius_limit)) ? radius_limit : POS_W'(div_q);
        end
        if (ctrl.load_blend)
        begin
            blx_reg <= blx_prod;
            bly_reg <= bly_prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg        <= POS_W'(START_X_RST);
            pos_y_reg        <= POS_W'(START_Y_RST);
            radius_reg       <= POS_W'(START_RADIUS_RST);
            dist_total_reg   <= '0;
            window_count_reg <= '0;
            min_x_reg        <= '1;
            max_x_reg        <= '0;
            min_y_reg        <= '1;
            max_y_reg        <= '0;
            width_held_reg   <= '0;
            height_held_reg  <= '0;
        end
        else if (ctrl.commit)
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            dist_total_reg <= dist_total_next;
            if (close_reg)
            begin
                radius_reg       <= rnew_reg;
                width_held_reg   <= max_x_reg - min_x_reg;
                height_held_reg  <= max_y_reg - min_y_reg;
                window_count_reg <= CNT_W'(1);
                min_x_reg        <= ex_reg;
                max_x_reg        <= ex_reg;
                min_y_reg        <= ey_reg;
                max_y_reg        <= ey_reg;
            end
            else
            begin
                window_count_reg <= window_count_reg + 1'b1;
                if (ex_reg < min_x_reg)
                begin
                    min_x_reg <= ex_reg;
                end
                if (ex_reg > max_x_reg)
                begin
                    max_x_reg <= ex_reg;
                end
                if (ey_reg < min_y_reg)
                begin
                    min_y_reg <= ey_reg;
                end
                if (ey_reg > max_y_reg)
                begin
                    max_y_reg <= ey_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctrl.load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_result)
        begin
            accepted_reg   <= hit_reg;
            center_x_reg   <= pos_x_reg;
            center_y_reg   <= pos_y_reg;
            radius_now_reg <= radius_reg;
            box_width_reg  <= width_held_reg;
            box_height_reg <= height_held_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (event_valid)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:    state_next = ST_SQUARE;
            ST_SQUARE:  state_next = ST_ROOT_GO;
            ST_ROOT_GO: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_GATE;
                end
            end
            ST_GATE:
            begin
                if (!hit_now)
                begin
                    state_next = ST_OUT;
                end
                else if (close_now)
                begin
                    state_next = ST_AVG_GO;
                end
                else
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_AVG_GO:  state_next = ST_AVG;
            ST_AVG:
            begin
                if (div_done)
                begin
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL:    state_next = ST_RSUM;
            ST_RSUM:    state_next = ST_RDIV_GO;
            ST_RDIV_GO: state_next = ST_RDIV;
            ST_RDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:   state_next = ST_COMMIT;
            ST_COMMIT:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:    ctrl.load_event  = event_valid;
            ST_DIFF:    ctrl.load_diff   = 1'b1;
            ST_SQUARE:  ctrl.load_square = 1'b1;
            ST_ROOT_GO: ctrl.sqrt_start  = 1'b1;
            ST_GATE:    ctrl.load_gate   = 1'b1;
            ST_AVG_GO:  ctrl.div_start   = 1'b1;
            ST_AVG:     ctrl.load_avg    = div_done;
            ST_RMUL:    ctrl.load_rmul   = 1'b1;
            ST_RSUM:    ctrl.load_rsum   = 1'b1;
            ST_RDIV_GO:
            begin
                ctrl.div_start  = 1'b1;
                ctrl.div_radius = 1'b1;
            end
            ST_RDIV:    ctrl.load_radius = div_done;
            ST_BLEND:   ctrl.load_blend  = 1'b1;
            ST_COMMIT:  ctrl.commit      = 1'b1;
            ST_OUT:     ctrl.load_result = out_free;
            default:    ctrl = '0;
        endcase
    end

    assign event_stall  = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign accepted     = accepted_reg;
    assign center_x     = center_x_reg;
    assign center_y     = center_y_reg;
    assign radius_now   = radius_now_reg;
    assign box_width    = box_width_reg;
    assign box_height   = box_height_reg;

endmodule

// ===== src/ebt_regs.sv =====
// Configuration register file on the APB-style port.
module ebt_regs import ebt_pkg::*; #(
    parameter int POS_W = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic [W_BITS-1:0] center_weight,
    output logic [W_BITS-1:0] radius_weight,
    output logic [POS_W-1:0]  radius_limit
);

    logic [W_BITS-1:0] center_weight_reg;
    logic [W_BITS-1:0] radius_weight_reg;
    logic [POS_W-1:0]  radius_limit_reg;
    logic [POS_W-1:0]  start_x_reg;
    logic [POS_W-1:0]  start_y_reg;
    logic [POS_W-1:0]  start_radius_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_weight_reg <= W_BITS'(CENTER_WEIGHT_RST);
            radius_weight_reg <= W_BITS'(RADIUS_WEIGHT_RST);
            radius_limit_reg  <= POS_W'(RADIUS_LIMIT_RST);
            start_x_reg       <= POS_W'(START_X_RST);
            start_y_reg       <= POS_W'(START_Y_RST);
            start_radius_reg  <= POS_W'(START_RADIUS_RST);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CENTER_WEIGHT: center_weight_reg <= pwdata[W_BITS-1:0];
                REG_RADIUS_WEIGHT: radius_weight_reg <= pwdata[W_BITS-1:0];
                REG_RADIUS_LIMIT:  radius_limit_reg  <= pwdata[POS_W-1:0];
                REG_START_X:       start_x_reg       <= pwdata[POS_W-1:0];
                REG_START_Y:       start_y_reg       <= pwdata[POS_W-1:0];
                REG_START_RADIUS:  start_radius_reg  <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CENTER_WEIGHT: prdata = DATA_W'(center_weight_reg);
            REG_RADIUS_WEIGHT: prdata = DATA_W'(radius_weight_reg);
            REG_RADIUS_LIMIT:  prdata = DATA_W'(radius_limit_reg);
            REG_START_X:       prdata = DATA_W'(start_x_reg);
            REG_START_Y:       prdata = DATA_W'(start_y_reg);
            REG_START_RADIUS:  prdata = DATA_W'(start_radius_reg);
            default:           prdata = '0;
        endcase
    end

    assign center_weight = center_weight_reg;
    assign radius_weight = radius_weight_reg;
    assign radius_limit  = radius_limit_reg;

endmodule

// ===== src/ebt_sqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
module ebt_sqrt #(
    parameter int RAD_W = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int TRY_W  = ROOT_W + 3;

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  test;
    logic [TRY_W-1:0]  trial_diff;
    logic              fits;
    logic              last;

    assign trial      = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign test       = {1'b0, root_reg, 2'b01};
    assign fits       = trial >= test;
    assign trial_diff = trial - test;
    assign last       = cnt_reg == CNT_W'(ROOT_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg & last;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            rem_reg  <= fits ? trial_diff[ROOT_W:0] : trial[ROOT_W:0];
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/ebt_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ebt_div #(
    parameter int N_W = 34,
    parameter int D_W = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [D_W:0]     trial;
    logic [D_W:0]     trial_diff;
    logic             fits;
    logic             last;

    assign trial      = {rem_reg, quo_reg[N_W-1]};
    assign fits       = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign last       = cnt_reg == CNT_W'(N_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg & last;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N_W-2:0], fits};
            rem_reg <= fits ? trial_diff[D_W-1:0] : trial[D_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== bench/event_blob_tracker_tb.sv =====
// Self-checking testbench for the event blob tracker: gating, center pull and window radius.
`timescale 1ns / 1ps

module event_blob_tracker_tb;
    import ebt_pkg::*;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 8;
    localparam int WINDOW_LEN = 200;
    localparam int POS_W      = COORD_BITS + FRAC_BITS;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam reg_idx_t REG_SPARE = 3'd6;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic                  accepted;
        logic [POS_W-1:0]      center_x;
        logic [POS_W-1:0]      center_y;
        logic [POS_W-1:0]      radius_now;
        logic [COORD_BITS-1:0] box_width;
        logic [COORD_BITS-1:0] box_height;
    } blob_result_t;

    class blob_scoreboard;
        blob_result_t          pending_q[$];
        int                    errors;
        int                    checked;
        int                    accepts;
        int                    rejects;
        int                    closes;
        logic [W_BITS-1:0]     beta;
        logic [W_BITS-1:0]     gamma;
        logic [POS_W-1:0]      r_limit;
        logic [POS_W-1:0]      st_x;
        logic [POS_W-1:0]      st_y;
        logic [POS_W-1:0]      st_r;
        logic [POS_W-1:0]      cen_x;
        logic [POS_W-1:0]      cen_y;
        logic [POS_W-1:0]      rad;
        logic [DIST_W-1:0]     dist_sum;
        logic [CNT_W-1:0]      win_cnt;
        logic [COORD_BITS-1:0] lo_x;
        logic [COORD_BITS-1:0] hi_x;
        logic [COORD_BITS-1:0] lo_y;
        logic [COORD_BITS-1:0] hi_y;
        logic [COORD_BITS-1:0] held_w;
        logic [COORD_BITS-1:0] held_h;

        function new();
            errors   = 0;
            checked  = 0;
            accepts  = 0;
            rejects  = 0;
            closes   = 0;
            beta     = W_BITS'(CENTER_WEIGHT_RST);
            gamma    = W_BITS'(RADIUS_WEIGHT_RST);
            r_limit  = POS_W'(RADIUS_LIMIT_RST);
            st_x     = POS_W'(START_X_RST);
            st_y     = POS_W'(START_Y_RST);
            st_r     = POS_W'(START_RADIUS_RST);
            cen_x    = st_x;
            cen_y    = st_y;
            rad      = st_r;
            dist_sum = '0;
            win_cnt  = '0;
            lo_x     = '1;
            hi_x     = '0;
            lo_y     = '1;
            hi_y     = '0;
            held_w   = '0;
            held_h   = '0;
        endfunction

        function void set_config(reg_idx_t idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_CENTER_WEIGHT: beta = v[W_BITS-1:0];
                REG_RADIUS_WEIGHT: gamma = v[W_BITS-1:0];
                REG_RADIUS_LIMIT:  r_limit = v[POS_W-1:0];
                REG_START_X:       st_x = v[POS_W-1:0];
                REG_START_Y:       st_y = v[POS_W-1:0];
                REG_START_RADIUS:  st_r = v[POS_W-1:0];
                default: ;
            endcase
        endfunction

        function u64_t root_floor(u64_t n);
            u64_t r;
            u64_t t;
            r = 0;
            for (int b = 20; b >= 0; b--)
            begin
                t = r | (u64_t'(1) << b);
                if (t * t <= n)
                    r = t;
            end
            return r;
        endfunction

        function logic [POS_W-1:0] pull(logic [POS_W-1:0] p, u64_t target);
            u64_t w;
            u64_t sum;
            w = u64_t'(beta);
            sum = (u64_t'(W_ONE) - w) * u64_t'(p) + w * target + u64_t'(ROUND_HALF);
            return POS_W'(sum >> W_BITS);
        endfunction

        function void note_event(logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
            u64_t         qx;
            u64_t         qy;
            u64_t         ddx;
            u64_t         ddy;
            u64_t         d;
            u64_t         avg;
            u64_t         num;
            u64_t         r;
            u64_t         s;
            logic         hit;
            blob_result_t want;
            qx  = u64_t'(ex) << FRAC_BITS;
            qy  = u64_t'(ey) << FRAC_BITS;
            ddx = (qx >= u64_t'(cen_x)) ? qx - u64_t'(cen_x) : u64_t'(cen_x) - qx;
            ddy = (qy >= u64_t'(cen_y)) ? qy - u64_t'(cen_y) : u64_t'(cen_y) - qy;
            d   = root_floor(ddx * ddx + ddy * ddy);
            hit = (d < u64_t'(rad));
            if (hit)
            begin
                accepts++;
                if (win_cnt == CNT_W'(WINDOW_LEN))
                begin
                    avg = u64_t'(dist_sum) / u64_t'(WINDOW_LEN);
                    num = (u64_t'(W_ONE) - u64_t'(gamma)) * u64_t'(rad) * u64_t'(RAD_SCALE)
                        + u64_t'(RAD_GAIN) * u64_t'(gamma) * avg;
                    r = num / (u64_t'(W_ONE) * u64_t'(RAD_SCALE));
                    held_w = hi_x - lo_x;
                    held_h = hi_y - lo_y;
                    if (r > u64_t'(r_limit))
                        r = u64_t'(r_limit);
                    rad      = POS_W'(r);
                    win_cnt  = '0;
                    dist_sum = '0;
                    lo_x     = ex;
                    hi_x     = ex;
                    lo_y     = ey;
                    hi_y     = ey;
                    closes++;
                end
                else
                begin
                    if (ex < lo_x) lo_x = ex;
                    if (ex > hi_x) hi_x = ex;
                    if (ey < lo_y) lo_y = ey;
                    if (ey > hi_y) hi_y = ey;
                end
                s = u64_t'(dist_sum) + d;
                if (s > u64_t'(DIST_MAX))
                    s = u64_t'(DIST_MAX);
                dist_sum = DIST_W'(s);
                cen_x    = pull(cen_x, qx);
                cen_y    = pull(cen_y, qy);
                win_cnt  = win_cnt + 1'b1;
            end
            else
                rejects++;
            want = '{hit, cen_x, cen_y, rad, held_w, held_h};
            pending_q.push_back(want);
        endfunction

        task report(string what, u64_t want_v, u64_t got_v);
            errors++;
            if (errors <= 100)
                $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want_v, got_v);
        endtask

        task check_result(blob_result_t got);
            blob_result_t want;
            if (pending_q.size() == 0)
            begin
                report("result word with nothing expected, center_x", 0, u64_t'(got.center_x));
                return;
            end
            want = pending_q.pop_front();
            if (got.accepted !== want.accepted)
                report($sformatf("word %0d accepted", checked),
                       u64_t'(want.accepted), u64_t'(got.accepted));
            if (got.center_x !== want.center_x)
                report($sformatf("word %0d center_x", checked),
                       u64_t'(want.center_x), u64_t'(got.center_x));
            if (got.center_y !== want.center_y)
                report($sformatf("word %0d center_y", checked),
                       u64_t'(want.center_y), u64_t'(got.center_y));
            if (got.radius_now !== want.radius_now)
                report($sformatf("word %0d radius_now", checked),
                       u64_t'(want.radius_now), u64_t'(got.radius_now));
            if (got.box_width !== want.box_width)
                report($sformatf("word %0d box_width", checked),
                       u64_t'(want.box_width), u64_t'(got.box_width));
            if (got.box_height !== want.box_height)
                report($sformatf("word %0d box_height", checked),
                       u64_t'(want.box_height), u64_t'(got.box_height));
            checked++;
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  event_valid;
    logic                  event_stall;
    logic [COORD_BITS-1:0] event_x;
    logic [COORD_BITS-1:0] event_y;
    logic                  result_valid;
    logic                  result_stall;
    logic                  accepted;
    logic [POS_W-1:0]      center_x;
    logic [POS_W-1:0]      center_y;
    logic [POS_W-1:0]      radius_now;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    blob_scoreboard sb;
    int  sent        = 0;
    int  reg_writes  = 0;
    int  hold_cycles = 0;
    int  goal_x      = 1024;
    int  goal_y      = 1024;
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;

    int dir_x[16] = '{10, 6, 0, 2047, 2047, 0, 1365, 682, 0, 9, 0, 7, 3, 1024, 1, 2};
    int dir_y[16] = '{0, 8, 10, 2047, 0, 2047, 682, 1365, 0, 0, 9, 7, 4, 1024, 1, 0};

    event_blob_tracker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_x      (event_x),
        .event_y      (event_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accepted     (accepted),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_now   (radius_now),
        .box_width    (box_width),
        .box_height   (box_height),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap(bit may_be_zero);
        int r;
        r = $urandom_range(0, 99);
        if (may_be_zero && r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_BITS-1:0] coord_clamp(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return '1;
        return COORD_BITS'(v);
    endfunction

    function automatic logic [DATA_W-1:0] reg_mask(reg_idx_t idx);
        if (idx == REG_CENTER_WEIGHT || idx == REG_RADIUS_WEIGHT)
            return (32'd1 << W_BITS) - 1;
        return (32'd1 << POS_W) - 1;
    endfunction

    // Mostly events around the tracked center, drifting toward a wandering goal.
    function automatic void next_event(output logic [COORD_BITS-1:0] x,
                                       output logic [COORD_BITS-1:0] y);
        int cx;
        int cy;
        int rp;
        int ox;
        int oy;
        int mode;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 49) == 0)
        begin
            goal_x = $urandom_range(0, COORD_MAX);
            goal_y = $urandom_range(0, COORD_MAX);
        end
        if (mode == 0)
        begin
            x = COORD_BITS'($urandom_range(0, COORD_MAX));
            y = COORD_BITS'($urandom_range(0, COORD_MAX));
            return;
        end
        cx = (int'(sb.cen_x) + 128) >> FRAC_BITS;
        cy = (int'(sb.cen_y) + 128) >> FRAC_BITS;
        rp = int'(sb.rad) >> FRAC_BITS;
        if (rp < 2)
            rp = 2;
        if (mode == 1)
        begin
            // right at the gate edge
            ox = $urandom_range(0, 1) ? rp : -rp;
            oy = int'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            ox = int'($urandom_range(0, 2 * rp)) - rp;
            oy = int'($urandom_range(0, 2 * rp)) - rp;
            ox += (goal_x > cx) ? rp / 4 : (goal_x < cx) ? -(rp / 4) : 0;
            oy += (goal_y > cy) ? rp / 4 : (goal_y < cy) ? -(rp / 4) : 0;
        end
        x = coord_clamp(cx + ox);
        y = coord_clamp(cy + oy);
    endfunction

    task automatic offer(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        int gap;
        event_x     <= x;
        event_y     <= y;
        event_valid <= 1'b1;
        do
            @(posedge clk);
        while (event_stall);
        sb.note_event(x, y);
        sent++;
        gap = tx_idle_on ? pick_gap(1'b1) : 0;
        if (gap > 0)
        begin
            event_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        event_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] m;
        apb_access(1'b1, idx, value, rd);
        sb.set_config(idx, value);
        reg_writes++;
        if (idx <= REG_START_RADIUS)
        begin
            apb_access(1'b0, idx, '0, rd);
            m = reg_mask(idx);
            if ((rd & m) != (value & m))
                sb.report($sformatf("readback of register %0d", idx),
                          u64_t'(value & m), u64_t'(rd & m));
        end
    endtask

    task automatic run_events(input int count, input bit until_close,
                              input int hold_at, input int pause_at);
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        int                    i;
        int                    closes0;
        closes0 = sb.closes;
        i = 0;
        while (i < count || (until_close && sb.closes == closes0 && i < 3 * count))
        begin
            if (i % 64 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i == hold_at)
            begin
                tx_idle_on  = 1'b0;
                hold_cycles = 400;
            end
            if (i == pause_at)
                drain();
            next_event(x, y);
            offer(x, y);
            i++;
        end
        drain();
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        bit s;
        result_stall = 1'b0;
        forever
        begin
            if (hold_cycles > 0)
            begin
                s = 1'b1;
                n = hold_cycles;
                hold_cycles = 0;
            end
            else if (rx_idle_on)
            begin
                s = ($urandom_range(0, 2) == 0);
                n = s ? pick_gap(1'b0) : $urandom_range(1, 8);
            end
            else
            begin
                s = 1'b0;
                n = $urandom_range(1, 8);
            end
            result_stall <= s;
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result({accepted, center_x, center_y, radius_now, box_width, box_height});
    end

    initial
    begin
        #(20_000_000);
        $display("event_blob_tracker regression: fail");
        $finish;
    end

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        event_valid = 1'b0;
        event_x     = '0;
        event_y     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // gate edges at the reset center, field corners, alternating bits
        foreach (dir_x[i])
            offer(COORD_BITS'(dir_x[i]), COORD_BITS'(dir_y[i]));
        drain();

        set_reg(REG_CENTER_WEIGHT, 32'h0);
        offer(11'd3, 11'd3);
        offer(11'd5, 11'd1);
        offer(11'd0, 11'd6);
        drain();
        set_reg(REG_CENTER_WEIGHT, 32'hFFFF_FFFF);
        offer(11'd4, 11'd4);
        offer(11'd9, 11'd9);
        offer(11'd1, 11'd2);
        drain();

        set_reg(REG_CENTER_WEIGHT, CENTER_WEIGHT_RST);
        run_events(400, 1'b0, -1, 200);

        set_reg(REG_RADIUS_WEIGHT, 32'hFFFF_FFFF);
        set_reg(REG_RADIUS_LIMIT, 32'hFFFF_FFFF);
        set_reg(REG_START_X, 32'hFFFF_FFFF);
        set_reg(REG_START_Y, (32'd1 << POS_W) - 1);
        set_reg(REG_START_RADIUS, $urandom);
        run_events(320, 1'b0, -1, -1);

        set_reg(REG_CENTER_WEIGHT, 32'h0);
        set_reg(REG_RADIUS_WEIGHT, 32'h0);
        set_reg(REG_RADIUS_LIMIT, $urandom_range(2560, 65535));
        set_reg(REG_START_X, 32'h0);
        set_reg(REG_SPARE, $urandom);
        run_events(180, 1'b0, -1, -1);

        set_reg(REG_CENTER_WEIGHT, $urandom);
        set_reg(REG_RADIUS_WEIGHT, $urandom);
        set_reg(REG_RADIUS_LIMIT, $urandom_range(1280, (1 << POS_W) - 1));
        set_reg(REG_START_Y, $urandom);
        set_reg(REG_START_RADIUS, 32'h0);
        run_events(400, 1'b0, 120, -1);

        // a zero limit collapses the gate at the next window close
        set_reg(REG_CENTER_WEIGHT, $urandom_range(3000, 30000));
        set_reg(REG_RADIUS_WEIGHT, $urandom);
        set_reg(REG_RADIUS_LIMIT, 32'h0);
        run_events(350, 1'b1, -1, -1);

        repeat (120) @(posedge clk);
        $display("Covered %0d events: %0d inside the gate, %0d outside, %0d windows closed.",
                 sent, sb.accepts, sb.rejects, sb.closes);
        $display("%0d register writes, %0d result words compared, %0d mismatches.",
                 reg_writes, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("event_blob_tracker regression: pass");
        else
            $display("event_blob_tracker regression: fail");
        $finish;
    end

endmodule
